// ===== rtl/lss_pkg.sv =====
// Shared types and constants for the line sensor steering block.
// Holds the register map, Q1.14 constants and the sensor-to-error table.
// No dependencies.
package lss_pkg;

	// register map (word index = paddr[3:2])
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_BASE_SPEED  = 2'd0;
	localparam reg_idx_t REG_MIN_SPEED   = 2'd1;
	localparam reg_idx_t REG_TURN_FACTOR = 2'd2;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 15;

	// Q1.14 fixed point
	localparam int Q14_FRAC = 14;
	localparam logic [29:0] Q14_HALF = 30'd8192;

	localparam logic [CFG_W-1:0] BASE_SPEED_RST  = 15'd11469;
	localparam logic [CFG_W-1:0] MIN_SPEED_RST   = 15'd3277;
	localparam logic [CFG_W-1:0] TURN_FACTOR_RST = 15'd4915;

	typedef logic signed [15:0] err_t;

	// Weighted line position per sensor pattern, weights -3,-1,+1,+3 from
	// bit 0 up, divided by 3*count and rounded to nearest, ties away from zero.
	function automatic err_t raw_error_lut(input logic [3:0] bits);
		err_t v;
		case (bits)
			4'h0: v = 16'sd0;
			4'h1: v = -16'sd16384;
			4'h2: v = -16'sd5461;
			4'h3: v = -16'sd10923;
			4'h4: v = 16'sd5461;
			4'h5: v = -16'sd5461;
			4'h6: v = 16'sd0;
			4'h7: v = -16'sd5461;
			4'h8: v = 16'sd16384;
			4'h9: v = 16'sd0;
			4'hA: v = 16'sd5461;
			4'hB: v = -16'sd1820;
			4'hC: v = 16'sd10923;
			4'hD: v = 16'sd1820;
			4'hE: v = 16'sd5461;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/line_sensor_steering.sv =====
// Line sensor steering: four-stage pipeline from sensor bits to wheel speeds.
// Depends on lss_pkg (register map, Q1.14 constants, error table).
// Configuration through an APB-style register port.
//
// Usage: one transaction on the input channel (in_valid/in_stall) carries
// the four line sensor bits of one control period. Each input transaction
// yields exactly one output transaction (out_valid/out_stall) carrying the
// raw error, the filtered error and the left and right wheel speeds.
// Throughput is one transaction per cycle unless the receiver stalls. The
// four register stages are error lookup and ring sum, reciprocal multiply
// for the mean, the gain multiply, and the rounding/clamp stage feeding
// the output register.
// When the receiver stalls, the result holds in the output register and
// the stages behind it keep filling; in_stall rises once every stage holds
// a transaction while the receiver stalls. Reset clears the error ring and
// write slot, empties the pipeline and loads the default speed registers.
// Registers should only be written while the pipeline is empty.
module line_sensor_steering #(
	parameter int FILTER_TAPS = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [3:0]                    sensor_bits,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [15:0]            raw_error,
	output logic signed [15:0]            smooth_error,
	output logic [15:0]                   speed_l,
	output logic [15:0]                   speed_r,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lss_pkg::ADDR_W-1:0]    paddr,
	input  logic [lss_pkg::DATA_W-1:0]    pwdata,
	output logic [lss_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int SLOT_W  = (FILTER_TAPS > 1) ? $clog2(FILTER_TAPS) : 1;
	localparam int SUM_W   = 16 + $clog2(FILTER_TAPS);
	localparam int HALF    = FILTER_TAPS / 2;
	localparam int SH      = SUM_W + 3;
	localparam int RECIP   = ((1 << SH) + FILTER_TAPS - 1) / FILTER_TAPS;
	localparam int RECIP_W = SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	// configuration registers
	logic [lss_pkg::CFG_W-1:0] base_speed_q;
	logic [lss_pkg::CFG_W-1:0] min_speed_q;
	logic [lss_pkg::CFG_W-1:0] turn_factor_q;
	logic                      cfg_wr;

	// ring state
	lss_pkg::err_t     hist_q [FILTER_TAPS];
	logic [SLOT_W-1:0] slot_q;

	// pipeline
	logic              valid_s1, valid_s2, valid_s3, out_valid_q;
	logic              rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic              accept;
	lss_pkg::err_t     raw_in;
	logic signed [SUM_W-1:0] sum_in;
	lss_pkg::err_t     raw_s1, raw_s2, raw_s3;
	logic signed [SUM_W-1:0] sum_s1;
	logic              neg_s1;
	logic [SUM_W-1:0]  mag_s1;
	logic [SUM_W-1:0]  num_s1;
	logic [PROD_W-1:0] recip_prod;
	logic [14:0]       mag_s2;
	logic              neg_s2, neg_s3;
	lss_pkg::err_t     smooth_s3;
	logic [29:0]       pm_s3;
	logic [29:0]       pm_rnd;
	logic [15:0]       p_rnd;
	logic signed [17:0] spd_lo, spd_hi, spd_l, spd_r, spd_min;
	lss_pkg::err_t     raw_q, smooth_q;
	logic [15:0]       left_q, right_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q  <= lss_pkg::BASE_SPEED_RST;
			min_speed_q   <= lss_pkg::MIN_SPEED_RST;
			turn_factor_q <= lss_pkg::TURN_FACTOR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lss_pkg::REG_BASE_SPEED:  base_speed_q  <= pwdata[lss_pkg::CFG_W-1:0];
				lss_pkg::REG_MIN_SPEED:   min_speed_q   <= pwdata[lss_pkg::CFG_W-1:0];
				lss_pkg::REG_TURN_FACTOR: turn_factor_q <= pwdata[lss_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lss_pkg::REG_BASE_SPEED:  prdata = lss_pkg::DATA_W'(base_speed_q);
			lss_pkg::REG_MIN_SPEED:   prdata = lss_pkg::DATA_W'(min_speed_q);
			lss_pkg::REG_TURN_FACTOR: prdata = lss_pkg::DATA_W'(turn_factor_q);
			default:                  prdata = '0;
		endcase
	end

	// stage handshake: a stage loads when empty or when the next one loads
	assign rdy_out  = ~out_valid_q | ~out_stall;
	assign rdy_s3   = ~valid_s3 | rdy_out;
	assign rdy_s2   = ~valid_s2 | rdy_s3;
	assign rdy_s1   = ~valid_s1 | rdy_s2;
	assign in_stall = ~rdy_s1;
	assign accept   = in_valid & rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1    <= in_valid;
			if (rdy_s2)  valid_s2    <= valid_s1;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_out) out_valid_q <= valid_s3;
		end
	end

	// error lookup and ring sum with the new error in the current slot
	always_comb begin
		raw_in = lss_pkg::raw_error_lut(sensor_bits);
		sum_in = '0;
		for (int i = 0; i < FILTER_TAPS; i++) begin
			if (slot_q == SLOT_W'(i))
				sum_in = sum_in + SUM_W'(raw_in);
			else
				sum_in = sum_in + SUM_W'(hist_q[i]);
		end
	end

	// ring update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int i = 0; i < FILTER_TAPS; i++)
				hist_q[i] <= '0;
		end else if (accept) begin
			for (int i = 0; i < FILTER_TAPS; i++) begin
				if (slot_q == SLOT_W'(i))
					hist_q[i] <= raw_in;
			end
			if (slot_q == SLOT_W'(FILTER_TAPS - 1))
				slot_q <= '0;
			else
				slot_q <= slot_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			raw_s1 <= raw_in;
			sum_s1 <= sum_in;
		end
	end

	// mean: magnitude plus half, exact floor divide by reciprocal multiply
	assign neg_s1     = sum_s1[SUM_W-1];
	assign mag_s1     = neg_s1 ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
	assign num_s1     = mag_s1 + SUM_W'(HALF);
	assign recip_prod = PROD_W'(num_s1) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			raw_s2 <= raw_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= recip_prod[SH +: 15];
		end
	end

	// signed mean and gain product on the magnitude
	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			raw_s3    <= raw_s2;
			neg_s3    <= neg_s2;
			smooth_s3 <= neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
			pm_s3     <= 30'(mag_s2) * 30'(turn_factor_q);
		end
	end

	// round the offset to nearest, ties away from zero, steer and clamp from below
	always_comb begin
		pm_rnd  = pm_s3 + lss_pkg::Q14_HALF;
		p_rnd   = pm_rnd[lss_pkg::Q14_FRAC +: 16];
		spd_lo  = $signed({3'b000, base_speed_q}) - $signed({2'b00, p_rnd});
		spd_hi  = $signed({3'b000, base_speed_q}) + $signed({2'b00, p_rnd});
		spd_min = $signed({3'b000, min_speed_q});
		spd_l   = neg_s3 ? spd_hi : spd_lo;
		spd_r   = neg_s3 ? spd_lo : spd_hi;
		if (spd_l < spd_min)
			spd_l = spd_min;
		if (spd_r < spd_min)
			spd_r = spd_min;
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			raw_q    <= raw_s3;
			smooth_q <= smooth_s3;
			left_q   <= spd_l[15:0];
			right_q  <= spd_r[15:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign raw_error    = raw_q;
	assign smooth_error = smooth_q;
	assign speed_l      = left_q;
	assign speed_r      = right_q;

endmodule

// ===== tb/sv/lss_steering_checker.sv =====
// Checker for line_sensor_steering: watches the sensor, result and register channels.
// Predicts every result from its own steering model and compares all of its fields.
// Depends on lss_pkg for the register map, reset values and Q1.14 scaling.
module lss_steering_checker #(
	parameter int FILTER_TAPS = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [3:0]                 sensor_bits,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [15:0]         raw_error,
	input  logic signed [15:0]         smooth_error,
	input  logic [15:0]                speed_l,
	input  logic [15:0]                speed_r,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [lss_pkg::ADDR_W-1:0] paddr,
	input  logic [lss_pkg::DATA_W-1:0] pwdata,
	input  logic                       wrap_up,
	output int                         results_seen,
	output int                         fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Q14_ONE = 1 << lss_pkg::Q14_FRAC;
	localparam int SENSOR_WEIGHT [4] = '{-3, -1, 1, 3};

	typedef struct packed {
		logic signed [15:0] raw;
		logic signed [15:0] smooth;
		logic [15:0]        left;
		logic [15:0]        right;
	} wheel_cmd_t;

	// steering model state, owned by the monitor process below
	wheel_cmd_t                wheel_cmd_q[$];
	int                        err_ring [FILTER_TAPS];
	int                        ring_slot;
	logic [lss_pkg::CFG_W-1:0] base_q, min_q, turn_q;
	int                        n_results, n_fail;
	bit                        wrapped;

	// divide by a positive divisor, nearest, ties away from zero
	function automatic int round_div(input int num, input int den);
		int mag;
		int q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// one control period: line position, ring update, mean, differential speeds
	function automatic wheel_cmd_t advance_steering(input logic [3:0] bits);
		wheel_cmd_t cmd;
		int wsum, cnt, raw, sum, smooth, prod, left, right;
		wsum = 0;
		cnt = 0;
		raw = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			if (bits[i]) begin
				wsum += SENSOR_WEIGHT[i];
				cnt++;
			end
		end
		if (cnt > 0)
			raw = round_div(wsum * Q14_ONE, 3 * cnt);
		err_ring[ring_slot] = raw;
		ring_slot = (ring_slot + 1) % FILTER_TAPS;
		for (int i = 0; i < FILTER_TAPS; i++)
			sum += err_ring[i];
		smooth = round_div(sum, FILTER_TAPS);
		prod = round_div(smooth * int'(turn_q), Q14_ONE);
		left = int'(base_q) - prod;
		right = int'(base_q) + prod;
		if (left < int'(min_q))
			left = int'(min_q);
		if (right < int'(min_q))
			right = int'(min_q);
		cmd.raw = raw[15:0];
		cmd.smooth = smooth[15:0];
		cmd.left = left[15:0];
		cmd.right = right[15:0];
		return cmd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wheel_cmd_t exp_cmd, got_cmd;
		if (!arst_n) begin
			wheel_cmd_q.delete();
			for (int i = 0; i < FILTER_TAPS; i++)
				err_ring[i] = 0;
			ring_slot = 0;
			base_q = lss_pkg::BASE_SPEED_RST;
			min_q = lss_pkg::MIN_SPEED_RST;
			turn_q = lss_pkg::TURN_FACTOR_RST;
			n_results = 0;
			n_fail = 0;
			wrapped = 0;
			results_seen <= 0;
			fail_count <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				n_results++;
				got_cmd = '{raw_error, smooth_error, speed_l, speed_r};
				if (wheel_cmd_q.size() == 0) begin
					if (n_fail < 10)
						$display("%0t: unexpected result: raw %0d smooth %0d l %0d r %0d",
							$time, got_cmd.raw, got_cmd.smooth, got_cmd.left,
							got_cmd.right);
					n_fail++;
				end else begin
					exp_cmd = wheel_cmd_q.pop_front();
					if (got_cmd !== exp_cmd) begin
						if (n_fail < 10)
							$display({"%0t: exp/got raw %0d/%0d smooth %0d/%0d",
								" l %0d/%0d r %0d/%0d"},
								$time, exp_cmd.raw, got_cmd.raw,
								exp_cmd.smooth, got_cmd.smooth,
								exp_cmd.left, got_cmd.left,
								exp_cmd.right, got_cmd.right);
						n_fail++;
					end
				end
			end
			// sensor transaction
			if (in_valid && !in_stall)
				wheel_cmd_q.push_back(advance_steering(sensor_bits));
			// register write completes in the access phase
			if (psel && penable && pwrite && pready) begin
				case (lss_pkg::reg_idx_t'(paddr[3:2]))
					lss_pkg::REG_BASE_SPEED:  base_q = pwdata[lss_pkg::CFG_W-1:0];
					lss_pkg::REG_MIN_SPEED:   min_q = pwdata[lss_pkg::CFG_W-1:0];
					lss_pkg::REG_TURN_FACTOR: turn_q = pwdata[lss_pkg::CFG_W-1:0];
					default: ;
				endcase
			end
			// end of run: anything still pending never came out
			if (wrap_up && !wrapped) begin
				wrapped = 1;
				if (wheel_cmd_q.size() != 0) begin
					$display("%0t: %0d results never arrived", $time, wheel_cmd_q.size());
					n_fail += wheel_cmd_q.size();
				end
			end
			results_seen <= n_results;
			fail_count <= n_fail;
		end
	end

endmodule

// ===== tb/sv/tb_line_sensor_steering.sv =====
// Testbench top for line_sensor_steering: clock, reset, sensor stimulus, register writes.
// Instantiates the block and lss_steering_checker, which does prediction and comparison.
// Depends on lss_pkg and tb/sv/lss_steering_checker.sv.
module tb_line_sensor_steering;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                FILTER_TAPS = 3;
	localparam int                LATENCY = 4;
	localparam int                PHASE_ITEMS = 125;
	localparam lss_pkg::reg_idx_t REG_SPARE = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [3:0]                    sensor_bits;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [15:0]            raw_error;
	logic signed [15:0]            smooth_error;
	logic [15:0]                   speed_l;
	logic [15:0]                   speed_r;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lss_pkg::ADDR_W-1:0]    paddr;
	logic [lss_pkg::DATA_W-1:0]    pwdata;
	logic [lss_pkg::DATA_W-1:0]    prdata;
	logic                          pready;
	logic                          wrap_up;
	int                            results_seen;
	int                            fail_count;

	int                            items_sent = 0;
	int                            send_idle_pct = 0;
	int                            stall_pct = 0;
	logic [3:0]                    line_bits = 4'h0;

	always #5 clk = ~clk;

	line_sensor_steering #(.FILTER_TAPS(FILTER_TAPS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sensor_bits(sensor_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.raw_error(raw_error), .smooth_error(smooth_error),
		.speed_l(speed_l), .speed_r(speed_r),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lss_steering_checker #(.FILTER_TAPS(FILTER_TAPS)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sensor_bits(sensor_bits),
		.out_valid(out_valid), .out_stall(out_stall),
		.raw_error(raw_error), .smooth_error(smooth_error),
		.speed_l(speed_l), .speed_r(speed_r),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.wrap_up(wrap_up), .results_seen(results_seen), .fail_count(fail_count)
	);

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// one sensor transaction, with random idle cycles ahead of it
	task automatic send_sensor(input logic [3:0] bits);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_bits <= bits;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// stop sending until every result is back, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (results_seen < items_sent)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// register write: setup cycle, then access cycle; upper bits carry noise
	task automatic write_reg(input lss_pkg::reg_idx_t idx,
			input logic [lss_pkg::CFG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~32'h7FFF) | lss_pkg::DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_speeds(input logic [lss_pkg::CFG_W-1:0] base,
			input logic [lss_pkg::CFG_W-1:0] minv,
			input logic [lss_pkg::CFG_W-1:0] turn);
		write_reg(lss_pkg::REG_BASE_SPEED, base);
		write_reg(lss_pkg::REG_MIN_SPEED, minv);
		write_reg(lss_pkg::REG_TURN_FACTOR, turn);
	endtask

	initial begin
		logic [3:0] directed [$];
		in_valid <= 1'b0;
		sensor_bits <= 4'h0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		wrap_up <= 1'b0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every sensor pattern at reset speeds, then hard right and hard left
		send_idle_pct = 30;
		stall_pct = 74;
		for (int b = 0; b < 16; b++)
			directed.push_back(4'(b));
		directed.push_back(4'h8);
		directed.push_back(4'h8);
		directed.push_back(4'h8);
		directed.push_back(4'h1);
		directed.push_back(4'h1);
		directed.push_back(4'h1);
		foreach (directed[i])
			send_sensor(directed[i]);

		// random phases, each with its own speed settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 74;
				stall_pct = 30;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			drain();
			case (ph)
				0: begin
					program_speeds(15'd16384, 15'd0, 15'd16384);
					write_reg(REG_SPARE, 15'($urandom()));
				end
				1: program_speeds(15'h7FFF, 15'h7FFF, 15'h7FFF);
				2: program_speeds(15'd0, 15'd0, 15'd0);
				3: program_speeds(15'($urandom_range(16384)), 15'($urandom_range(16384)),
						15'($urandom_range(16384)));
				4: program_speeds(15'($urandom()), 15'($urandom_range(8192)), 15'($urandom()));
				default: program_speeds(lss_pkg::BASE_SPEED_RST, lss_pkg::MIN_SPEED_RST,
						lss_pkg::TURN_FACTOR_RST);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the line position now and then so the filter settles
				if (ph == 1 && i == 60)
					drain();
				if ($urandom_range(99) >= 40)
					line_bits = 4'($urandom_range(15));
				send_sensor(line_bits);
			end
		end

		drain();
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("tb_line_sensor_steering: done, clean");
		else
			$display("tb_line_sensor_steering: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb_line_sensor_steering: done, errors");
		$finish;
	end

endmodule
